@@ rtl/dual_modulus_clock_divider_defines.svh @@
// Assertion helpers for the divider RTL.
`ifndef DUAL_MODULUS_CLOCK_DIVIDER_DEFINES_SVH
`define DUAL_MODULUS_CLOCK_DIVIDER_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define DMCD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dmcd assertion failed");

// Check that a condition holds in the cycle after its trigger.
`define DMCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dmcd assertion failed");

`endif

@@ rtl/dmcd_pkg.sv @@
`default_nettype none

package dmcd_pkg;

   // Default width of the divisor and count fields.
   localparam int FIELD_BITS_DEFAULT = 12;

   // Byte address width of the register port (five registers at 4*i).
   localparam int ADDR_BITS = 5;

   // Register word index within the register port.
   typedef enum logic [2:0] {
      REG_DUAL_MODE     = 3'd0,
      REG_FIRST_DIV     = 3'd1,
      REG_FIRST_COUNT   = 3'd2,
      REG_SECOND_DIV    = 3'd3,
      REG_SECOND_COUNT  = 3'd4
   } reg_index_type;

   // One result transaction.
   typedef struct packed {
      logic period_strobe;
      logic active_phase;
   } result_type;

endpackage

`default_nettype wire

@@ rtl/dmcd_csr.sv @@
`default_nettype none

module dmcd_csr
   import dmcd_pkg::*;
#(
   parameter int FIELD_BITS = FIELD_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [ADDR_BITS-1:0]  paddr,
   input  wire logic [31:0]           pwdata,
   output logic      [31:0]           prdata,
   output logic                       pready,
   output logic                       dual_mode,
   output logic      [FIELD_BITS-1:0] first_div,
   output logic      [FIELD_BITS-1:0] first_count,
   output logic      [FIELD_BITS-1:0] second_div,
   output logic      [FIELD_BITS-1:0] second_count
);

   logic                  dual_ff;
   logic [FIELD_BITS-1:0] first_div_ff;
   logic [FIELD_BITS-1:0] first_count_ff;
   logic [FIELD_BITS-1:0] second_div_ff;
   logic [FIELD_BITS-1:0] second_count_ff;
   logic                  wr_en;
   logic [2:0]            word_index;

   assign pready     = 1'b1;
   assign wr_en      = psel & penable & pwrite;
   assign word_index = paddr[ADDR_BITS-1:2];

   // Write the selected register in the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         dual_ff         <= 1'b0;
         first_div_ff    <= '0;
         first_count_ff  <= '0;
         second_div_ff   <= '0;
         second_count_ff <= '0;
      end else if (wr_en) begin
         case (word_index)
            REG_DUAL_MODE:    dual_ff         <= pwdata[0];
            REG_FIRST_DIV:    first_div_ff    <= pwdata[FIELD_BITS-1:0];
            REG_FIRST_COUNT:  first_count_ff  <= pwdata[FIELD_BITS-1:0];
            REG_SECOND_DIV:   second_div_ff   <= pwdata[FIELD_BITS-1:0];
            REG_SECOND_COUNT: second_count_ff <= pwdata[FIELD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Return the addressed register, zero extended
   always_comb begin
      case (word_index)
         REG_DUAL_MODE:    prdata = {31'd0, dual_ff};
         REG_FIRST_DIV:    prdata = 32'(first_div_ff);
         REG_FIRST_COUNT:  prdata = 32'(first_count_ff);
         REG_SECOND_DIV:   prdata = 32'(second_div_ff);
         REG_SECOND_COUNT: prdata = 32'(second_count_ff);
         default:          prdata = 32'd0;
      endcase
   end

   assign dual_mode    = dual_ff;
   assign first_div    = first_div_ff;
   assign first_count  = first_count_ff;
   assign second_div   = second_div_ff;
   assign second_count = second_count_ff;

endmodule

`default_nettype wire

@@ rtl/dmcd_step.sv @@
`default_nettype none

module dmcd_step
   import dmcd_pkg::*;
#(
   parameter int FIELD_BITS = FIELD_BITS_DEFAULT
) (
   input  wire logic                  tick,
   input  wire logic                  dual_mode,
   input  wire logic [FIELD_BITS-1:0] first_div,
   input  wire logic [FIELD_BITS-1:0] first_count,
   input  wire logic [FIELD_BITS-1:0] second_div,
   input  wire logic [FIELD_BITS-1:0] second_count,
   input  wire logic [FIELD_BITS-1:0] tick_cnt,
   input  wire logic [FIELD_BITS-1:0] period_cnt,
   input  wire logic                  phase,
   output logic      [FIELD_BITS-1:0] tick_cnt_in,
   output logic      [FIELD_BITS-1:0] period_cnt_in,
   output logic                       phase_in,
   output result_type                 result
);

   localparam logic [FIELD_BITS-1:0] ONE = {{(FIELD_BITS-1){1'b0}}, 1'b1};

   logic                  cur_phase;
   logic [FIELD_BITS-1:0] divisor;
   logic [FIELD_BITS-1:0] count;

   // Single mode always runs the first divider
   assign cur_phase = dual_mode & phase;
   assign divisor   = cur_phase ? second_div : first_div;
   assign count     = cur_phase ? second_count : first_count;

   // Advance the tick and period counters for one parent tick
   always_comb begin
      tick_cnt_in          = tick_cnt;
      period_cnt_in        = period_cnt;
      phase_in             = phase;
      result.period_strobe = 1'b0;
      result.active_phase  = cur_phase;
      if (tick) begin
         if (!dual_mode) begin
            period_cnt_in = '0;
            phase_in      = 1'b0;
         end
         // Compare with >= so a lowered divisor or count ends the run at once
         if (tick_cnt >= divisor) begin
            result.period_strobe = 1'b1;
            tick_cnt_in          = '0;
            if (dual_mode) begin
               if (period_cnt >= count) begin
                  period_cnt_in = '0;
                  phase_in      = ~cur_phase;
               end else begin
                  period_cnt_in = period_cnt + ONE;
               end
            end
         end else begin
            tick_cnt_in = tick_cnt + ONE;
         end
      end
   end

endmodule

`default_nettype wire

@@ rtl/dual_modulus_clock_divider.sv @@
`default_nettype none
// Dual-modulus clock divider.
// Each req transaction carries one parent tick slot (req_parent_tick). Each
// one yields exactly one rsp transaction: rsp_period_strobe is 1 when that
// tick closes an output period, rsp_active_phase names the divider in use.
// Single mode: every period is first divisor + 1 ticks. Dual mode: first
// count + 1 periods of first divisor + 1 ticks, then second count + 1
// periods of second divisor + 1 ticks, repeating.
// A req enters the input register, then passes the counter update into the
// result register, which drives rsp_valid. Throughput is one transaction per
// cycle while the receiver does not stall; the counter compare and increment
// sit between the input register and the result register. When the receiver
// stalls, the result register holds and one more transaction waits in the
// input register; req_ready then drops. The user must write registers over
// the APB-style port only while no transaction is in flight (not enforced).
// Reset (synchronous) clears registers, counters and both stages.
module dual_modulus_clock_divider
   import dmcd_pkg::*;
#(
   parameter int FIELD_BITS = FIELD_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_parent_tick,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_period_strobe,
   output logic                      rsp_active_phase,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [ADDR_BITS-1:0] paddr,
   input  wire logic [31:0]          pwdata,
   output logic      [31:0]          prdata,
   output logic                      pready
);

`include "dual_modulus_clock_divider_defines.svh"

   logic                  dual_mode;
   logic [FIELD_BITS-1:0] first_div;
   logic [FIELD_BITS-1:0] first_count;
   logic [FIELD_BITS-1:0] second_div;
   logic [FIELD_BITS-1:0] second_count;

   logic                  in_valid_ff;
   logic                  in_tick_ff;
   logic [FIELD_BITS-1:0] tick_cnt_ff;
   logic [FIELD_BITS-1:0] tick_cnt_in;
   logic [FIELD_BITS-1:0] period_cnt_ff;
   logic [FIELD_BITS-1:0] period_cnt_in;
   logic                  phase_ff;
   logic                  phase_in;
   logic                  out_valid_ff;
   result_type            out_ff;
   result_type            result;
   logic                  advance;

   dmcd_csr #(
      .FIELD_BITS (FIELD_BITS)
   ) u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .dual_mode    (dual_mode),
      .first_div    (first_div),
      .first_count  (first_count),
      .second_div   (second_div),
      .second_count (second_count)
   );

   dmcd_step #(
      .FIELD_BITS (FIELD_BITS)
   ) u_step (
      .tick          (in_tick_ff),
      .dual_mode     (dual_mode),
      .first_div     (first_div),
      .first_count   (first_count),
      .second_div    (second_div),
      .second_count  (second_count),
      .tick_cnt      (tick_cnt_ff),
      .period_cnt    (period_cnt_ff),
      .phase         (phase_ff),
      .tick_cnt_in   (tick_cnt_in),
      .period_cnt_in (period_cnt_in),
      .phase_in      (phase_in),
      .result        (result)
   );

   // Move the held transaction on when the result register is free or draining
   assign advance   = in_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;

   // Input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_tick_ff <= req_parent_tick;
      end
   end

   // Divider state, updated once per processed transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_cnt_ff   <= '0;
         period_cnt_ff <= '0;
         phase_ff      <= 1'b0;
      end else if (advance) begin
         tick_cnt_ff   <= tick_cnt_in;
         period_cnt_ff <= period_cnt_in;
         phase_ff      <= phase_in;
      end
   end

   // Result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_period_strobe = out_ff.period_strobe;
   assign rsp_active_phase  = out_ff.active_phase;

   // A strobe always restarts the tick count
   `DMCD_ASSERT_NEXT(a_strobe_clears, clock, reset, advance && result.period_strobe, tick_cnt_ff == '0)
   // Single mode leaves the phase and period count cleared after a tick
   `DMCD_ASSERT_NEXT(a_single_clear, clock, reset, advance && in_tick_ff && !dual_mode, !phase_ff && period_cnt_ff == '0)
   // The tick count and phase hold when no transaction is processed
   `DMCD_ASSERT_NEXT(a_hold_state, clock, reset, !advance, $stable(tick_cnt_ff) && $stable(phase_ff))
   // An empty result stage never blocks the input
   `DMCD_ASSERT_SAME(a_ready_empty, clock, reset, !out_valid_ff, req_ready)

endmodule

`default_nettype wire

@@ test/dmcd_result_checker.sv @@
`default_nettype none

module dmcd_result_checker
   import dmcd_pkg::*;
#(
   parameter int FIELD_BITS = FIELD_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire logic                 req_parent_tick,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire logic                 rsp_period_strobe,
   input  wire logic                 rsp_active_phase,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic                 pready,
   input  wire logic [ADDR_BITS-1:0] paddr,
   input  wire logic [31:0]          pwdata,
   output int                        outstanding,
   output int                        mismatches
);

   // Shadow copy of the divider registers
   logic                  dual_mode;
   logic [FIELD_BITS-1:0] first_div;
   logic [FIELD_BITS-1:0] first_count;
   logic [FIELD_BITS-1:0] second_div;
   logic [FIELD_BITS-1:0] second_count;

   // Shadow copy of the divider counters
   logic [FIELD_BITS-1:0] tick_count;
   logic [FIELD_BITS-1:0] period_count;
   logic                  second_phase;

   result_type expected_strobes[$];
   int         error_count = 0;

   task automatic report_failure(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      error_count++;
   endtask

   // Advance the divider by one tick slot and return the strobe it yields
   task automatic advance_divider(input logic tick, output result_type res);
      logic                  phase;
      logic [FIELD_BITS-1:0] divisor;
      logic [FIELD_BITS-1:0] count;
      phase = dual_mode ? second_phase : 1'b0;
      res.period_strobe = 1'b0;
      res.active_phase  = phase;
      if (tick) begin
         divisor = phase ? second_div : first_div;
         count   = phase ? second_count : first_count;
         // Single mode pins the phase and period count
         if (!dual_mode) begin
            second_phase = 1'b0;
            period_count = '0;
         end
         if (tick_count >= divisor) begin
            res.period_strobe = 1'b1;
            tick_count = '0;
            if (dual_mode) begin
               if (period_count >= count) begin
                  period_count = '0;
                  second_phase = ~phase;
               end else begin
                  period_count = period_count + 1'b1;
               end
            end
         end else begin
            tick_count = tick_count + 1'b1;
         end
      end
   endtask

   always @(posedge clock) begin
      result_type predicted;
      result_type oldest;
      if (reset) begin
         dual_mode    = 1'b0;
         first_div    = '0;
         first_count  = '0;
         second_div   = '0;
         second_count = '0;
         tick_count   = '0;
         period_count = '0;
         second_phase = 1'b0;
         expected_strobes.delete();
      end else begin
         // Track register writes
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[ADDR_BITS-1:2]))
               REG_DUAL_MODE:    dual_mode    = pwdata[0];
               REG_FIRST_DIV:    first_div    = pwdata[FIELD_BITS-1:0];
               REG_FIRST_COUNT:  first_count  = pwdata[FIELD_BITS-1:0];
               REG_SECOND_DIV:   second_div   = pwdata[FIELD_BITS-1:0];
               REG_SECOND_COUNT: second_count = pwdata[FIELD_BITS-1:0];
               default: ;
            endcase
         end
         // Compare each result transaction with the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (expected_strobes.size() == 0) begin
               report_failure("result transaction with no prediction pending");
            end else begin
               oldest = expected_strobes.pop_front();
               if (rsp_period_strobe !== oldest.period_strobe)
                  report_failure($sformatf("period_strobe expected %0b, got %0b",
                                           oldest.period_strobe, rsp_period_strobe));
               if (rsp_active_phase !== oldest.active_phase)
                  report_failure($sformatf("active_phase expected %0b, got %0b",
                                           oldest.active_phase, rsp_active_phase));
            end
         end
         // Predict each accepted tick transaction
         if (req_valid && req_ready) begin
            advance_divider(req_parent_tick, predicted);
            expected_strobes.push_back(predicted);
         end
      end
      outstanding <= expected_strobes.size();
      mismatches  <= error_count;
   end

endmodule

`default_nettype wire

@@ test/dual_modulus_clock_divider_tb.sv @@
`default_nettype none

module dual_modulus_clock_divider_tb;
   import dmcd_pkg::*;

   localparam int FIELD_BITS   = FIELD_BITS_DEFAULT;
   localparam int LATENCY      = 2;
   localparam int RANDOM_ITEMS = 1650;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int FIELD_MAX    = (1 << FIELD_BITS) - 1;

   logic                 clock;
   logic                 reset           = 1'b1;
   logic                 req_valid       = 1'b0;
   logic                 req_parent_tick = 1'b0;
   logic                 rsp_ready       = 1'b0;
   logic                 psel            = 1'b0;
   logic                 penable         = 1'b0;
   logic                 pwrite          = 1'b0;
   logic [ADDR_BITS-1:0] paddr           = '0;
   logic [31:0]          pwdata          = '0;

   wire logic        req_ready;
   wire logic        rsp_valid;
   wire logic        rsp_period_strobe;
   wire logic        rsp_active_phase;
   wire logic [31:0] prdata;
   wire logic        pready;

   int outstanding;
   int mismatches;
   int cycles       = 0;
   int random_items = 0;
   int ready_left   = 0;
   int stall_left   = 0;

   dual_modulus_clock_divider #(
      .FIELD_BITS(FIELD_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_parent_tick(req_parent_tick),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_period_strobe(rsp_period_strobe),
      .rsp_active_phase(rsp_active_phase),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   dmcd_result_checker #(
      .FIELD_BITS(FIELD_BITS)
   ) u_result_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_parent_tick(req_parent_tick),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_period_strobe(rsp_period_strobe),
      .rsp_active_phase(rsp_active_phase),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .pready(pready),
      .paddr(paddr),
      .pwdata(pwdata),
      .outstanding(outstanding),
      .mismatches(mismatches)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // End the run if it hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Stall the receiver: ready runs of random length, short or long stalls
   always @(posedge clock) begin
      if (ready_left != 0) begin
         rsp_ready <= 1'b1;
         ready_left = ready_left - 1;
      end else if (stall_left != 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         ready_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 24);
         stall_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12)
                                                  : $urandom_range(0, 2);
      end
   end

   // Write one register over the APB port, then return the bus to idle
   task automatic write_reg(input reg_index_type idx, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Present one tick transaction and hold it until accepted
   task automatic send_tick(input logic tick);
      req_valid       <= 1'b1;
      req_parent_tick <= tick;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Send a fixed tick pattern back to back, lsb first
   task automatic send_pattern(input logic [15:0] bits, input int count);
      for (int i = 0; i < count; i++) send_tick(bits[i]);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait until every predicted result has come back, then let the pipe settle
   task automatic drain();
      repeat (2) @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   // Send random ticks in bursts with random gaps
   task automatic run_phase(input int count, input int tick_pct);
      int len;
      int gap;
      while (count > 0) begin
         len = $urandom_range(1, 30);
         if (len > count) len = count;
         for (int i = 0; i < len; i++) begin
            send_tick($urandom_range(0, 99) < tick_pct);
            random_items++;
         end
         count = count - len;
         case ($urandom_range(0, 9))
            0, 1, 2: gap = 0;
            3:       gap = $urandom_range(8, 20);
            default: gap = $urandom_range(1, 5);
         endcase
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic int pick_divisor();
      case ($urandom_range(0, 9))
         0:       return FIELD_MAX;
         1:       return $urandom_range(0, FIELD_MAX);
         2:       return 0;
         default: return $urandom_range(0, 7);
      endcase
   endfunction

   function automatic int pick_count();
      case ($urandom_range(0, 9))
         0:       return FIELD_MAX;
         1:       return $urandom_range(0, FIELD_MAX);
         2:       return 0;
         default: return $urandom_range(0, 5);
      endcase
   endfunction

   // Sometimes fill the unused upper bits to exercise masking
   function automatic logic [31:0] with_noise(input int value, input int bits);
      logic [31:0] noise;
      noise = $urandom();
      if ($urandom_range(0, 3) == 0) return (noise << bits) | value;
      return value;
   endfunction

   task automatic write_random_reg(input reg_index_type idx);
      case (idx)
         REG_DUAL_MODE:    write_reg(idx, with_noise($urandom_range(0, 9) < 7, 1));
         REG_FIRST_DIV,
         REG_SECOND_DIV:   write_reg(idx, with_noise(pick_divisor(), FIELD_BITS));
         default:          write_reg(idx, with_noise(pick_count(), FIELD_BITS));
      endcase
   endtask

   initial begin
      int tick_pct;
      int writes;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults: every tick closes a period, no tick holds
      send_pattern(16'b1101, 4);
      drain();

      // Dual mode with short phases, including idle slots
      write_reg(REG_DUAL_MODE, 32'd1);
      write_reg(REG_FIRST_DIV, 32'd1);
      write_reg(REG_FIRST_COUNT, 32'd0);
      write_reg(REG_SECOND_DIV, 32'd0);
      write_reg(REG_SECOND_COUNT, 32'd1);
      send_pattern(16'b11_1011_1111, 10);
      drain();

      // Largest values in single mode, then lower the divisor mid-period
      write_reg(REG_DUAL_MODE, 32'd0);
      write_reg(REG_FIRST_DIV, FIELD_MAX);
      write_reg(REG_FIRST_COUNT, FIELD_MAX);
      write_reg(REG_SECOND_DIV, FIELD_MAX);
      write_reg(REG_SECOND_COUNT, FIELD_MAX);
      send_pattern(16'b11_1111, 6);
      drain();
      write_reg(REG_FIRST_DIV, 32'd2);
      send_pattern(16'b11, 2);
      drain();

      // Random phases: new settings, then random tick traffic
      while (random_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            writes = $urandom_range(1, 2);
            for (int i = 0; i < writes; i++)
               write_random_reg(reg_index_type'($urandom_range(0, 4)));
         end else begin
            write_random_reg(REG_DUAL_MODE);
            write_random_reg(REG_FIRST_DIV);
            write_random_reg(REG_FIRST_COUNT);
            write_random_reg(REG_SECOND_DIV);
            write_random_reg(REG_SECOND_COUNT);
         end
         case ($urandom_range(0, 9))
            0, 1, 2: tick_pct = 100;
            3, 4:    tick_pct = $urandom_range(0, 30);
            default: tick_pct = $urandom_range(50, 95);
         endcase
         run_phase($urandom_range(30, 140), tick_pct);
         drain();
      end

      drain();
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire
